// ===== rtl/servo_step_profile_generator_defines.svh =====
// assertion macros shared by the servo step profile checker
`ifndef SERVO_STEP_PROFILE_GENERATOR_DEFINES_SVH
`define SERVO_STEP_PROFILE_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssp_pkg.sv =====
// types and constants of the servo step profile generator
`timescale 1ns / 1ps

package ssp_pkg;

  // field widths
  localparam int ANGLE_W     = 8;
  localparam int HOLD_W      = 14;
  localparam int PULSE_W     = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // move shaping
  localparam int STEP_DEG    = 10;
  localparam int MAX_RESULTS = 18;
  localparam int MIN_HOLD_MS = 10;
  localparam int ANGLE_LIMIT = 90;
  localparam int PULSE_BASE  = 1000;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // divide by the step size: multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT   = 16;
  localparam int STEP_RECIP  = (2**DIV_SHIFT + STEP_DEG - 1) / STEP_DEG;
  localparam int DIV_PROD_W  = ANGLE_W + DIV_SHIFT + 1;

  // 50/9 scaling of the shifted angle as one constant multiply
  localparam int PULSE_SHIFT  = 16;
  localparam int PULSE_RECIP  = (50 * 2**PULSE_SHIFT + 8) / 9;
  localparam int PULSE_PROD_W = ANGLE_W + $clog2(PULSE_RECIP + 1);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic step;
  } ssp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_move;
    logic final_step;
    logic can_emit;
  } ssp_stat_t;

endpackage

// ===== rtl/ssp_ctrl.sv =====
// sequencing state machine of the servo step profile generator
`timescale 1ns / 1ps

module ssp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ssp_pkg::ssp_stat_t stat,
  output ssp_pkg::ssp_cmd_t  cmd
);
  import ssp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // handshake and commands
  assign in_tready = (state_r == ST_IDLE);
  assign cmd.load  = in_tvalid && in_tready;
  assign cmd.calc  = (state_r == ST_CALC);
  assign cmd.step  = (state_r == ST_EMIT) && stat.can_emit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = stat.no_move ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.step && stat.final_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ssp_datapath.sv =====
// angle, step count and pulse width datapath with the result register
`timescale 1ns / 1ps

module ssp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssp_pkg::ssp_cmd_t                   cmd,
  output ssp_pkg::ssp_stat_t                  stat,
  input  logic [ssp_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_we,
  input  logic                                cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ssp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import ssp_pkg::*;

  logic                      invert_r;
  logic signed [ANGLE_W-1:0] cur_r;
  logic signed [ANGLE_W-1:0] target_r;
  logic [HOLD_W-1:0]         hold_r;
  logic signed [ANGLE_W-1:0] pos_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r;

  logic                      out_valid_r;
  logic [PULSE_W-1:0]        out_pulse_r;
  logic [HOLD_W-1:0]         out_hold_r;
  logic signed [ANGLE_W-1:0] out_pos_r;
  logic                      out_last_r;

  logic signed [ANGLE_W-1:0] raw_deg;
  logic signed [ANGLE_W-1:0] sat_deg;
  logic [HOLD_W-1:0]         raw_hold;
  logic [HOLD_W-1:0]         sat_hold;

  logic signed [ANGLE_W:0]   delta;
  logic [ANGLE_W:0]          mag;
  logic [DIV_PROD_W-1:0]     div_prod;
  logic [ANGLE_W-1:0]        n_steps;
  logic [ANGLE_W-1:0]        n_inter;

  logic signed [ANGLE_W-1:0] step_pos;
  logic signed [ANGLE_W-1:0] emit_pos;
  logic signed [ANGLE_W:0]   d_ext;
  logic signed [ANGLE_W:0]   d_lim;
  logic [ANGLE_W-1:0]        d_off;
  logic [PULSE_PROD_W-1:0]   pulse_prod;
  logic [PULSE_W-1:0]        pulse;

  // input saturation
  assign raw_deg  = in_tdata[ANGLE_W-1:0];
  assign raw_hold = in_tdata[ANGLE_W +: HOLD_W];
  always_comb begin
    if (raw_deg > ANGLE_W'(ANGLE_LIMIT)) begin
      sat_deg = ANGLE_W'(ANGLE_LIMIT);
    end else if (raw_deg < -ANGLE_W'(ANGLE_LIMIT)) begin
      sat_deg = -ANGLE_W'(ANGLE_LIMIT);
    end else begin
      sat_deg = raw_deg;
    end
    sat_hold = (raw_hold < HOLD_W'(MIN_HOLD_MS)) ? HOLD_W'(MIN_HOLD_MS) : raw_hold;
  end

  // distance to target and step count
  always_comb begin
    delta    = {target_r[ANGLE_W-1], target_r} - {cur_r[ANGLE_W-1], cur_r};
    mag      = delta[ANGLE_W] ? -delta : delta;
    div_prod = DIV_PROD_W'(mag) * DIV_PROD_W'(STEP_RECIP);
    n_steps  = div_prod[DIV_SHIFT +: ANGLE_W];
    n_inter  = n_steps - ANGLE_W'(1);
    if (n_inter > ANGLE_W'(MAX_RESULTS - 1)) n_inter = ANGLE_W'(MAX_RESULTS - 1);
  end

  // position of the step being issued
  assign step_pos = neg_r ? (pos_r - ANGLE_W'(STEP_DEG)) : (pos_r + ANGLE_W'(STEP_DEG));
  assign emit_pos = (cnt_r == '0) ? target_r : step_pos;

  // pulse width: optional negate, clamp, offset, scale by 50/9
  always_comb begin
    d_ext = {emit_pos[ANGLE_W-1], emit_pos};
    d_lim = invert_r ? -d_ext : d_ext;
    if (d_lim > (ANGLE_W+1)'(ANGLE_LIMIT)) begin
      d_lim = (ANGLE_W+1)'(ANGLE_LIMIT);
    end else if (d_lim < -(ANGLE_W+1)'(ANGLE_LIMIT)) begin
      d_lim = -(ANGLE_W+1)'(ANGLE_LIMIT);
    end
    d_off      = ANGLE_W'(d_lim + (ANGLE_W+1)'(ANGLE_LIMIT));
    pulse_prod = PULSE_PROD_W'(d_off) * PULSE_PROD_W'(PULSE_RECIP);
    pulse      = PULSE_W'(PULSE_BASE) + PULSE_W'(pulse_prod >> PULSE_SHIFT);
  end

  // status back to the controller
  assign stat.no_move    = (n_steps == '0);
  assign stat.final_step = (cnt_r == '0);
  assign stat.can_emit   = !out_valid_r || out_tready;

  // control state: invert, current angle, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r    <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) invert_r <= cfg_data;
      if (cmd.step && (cnt_r == '0)) cur_r <= target_r;
      if (cmd.step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // move registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_r <= sat_deg;
      hold_r   <= sat_hold;
    end
    if (cmd.calc) begin
      pos_r <= cur_r;
      neg_r <= delta[ANGLE_W];
      cnt_r <= CNT_W'(n_inter);
    end else if (cmd.step && (cnt_r != '0)) begin
      pos_r <= step_pos;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_pulse_r <= pulse;
      out_hold_r  <= hold_r;
      out_pos_r   <= emit_pos;
      out_last_r  <= (cnt_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_pos_r, out_hold_r, out_pulse_r});

endmodule

// ===== rtl/servo_step_profile_generator.sv =====
// Servo step profile generator: walks the servo angle toward each target in fixed steps.
// An accepted beat is loaded, then counted, then issued as its first result beat; an issue waits
// while the result register holds a stalled beat. Throughput: one result beat per cycle while out_tready
// is high; the input stays closed until an item's last result (at most 18) is issued or it causes none.
// Reset (rst_n low, synchronous): controller to idle, current angle 0, invert 0, no result.
`timescale 1ns / 1ps

module servo_step_profile_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] target_deg, [21:8] step_hold_ms, [23:22] zero
  input  logic [ssp_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [10:0] pulse_us, [24:11] hold_ms, [32:25] position_deg, [39:33] zero
  output logic [ssp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);
  import ssp_pkg::*;

  ssp_cmd_t  cmd;
  ssp_stat_t stat;

  // the invert register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencing
  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and result register
  ssp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/ssp_checker.sv =====
// port-level checks of the servo step profile generator, bound to the top level
`timescale 1ns / 1ps
`include "servo_step_profile_generator_defines.svh"

module ssp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import ssp_pkg::*;

  logic [PULSE_W-1:0] pulse_obs;
  logic               pulse_ok;
  logic               out_stall;

  assign pulse_obs = out_tdata[PULSE_W-1:0];
  assign pulse_ok  = (pulse_obs >= PULSE_W'(PULSE_BASE)) &&
                     (pulse_obs <= PULSE_W'(2 * PULSE_BASE));
  assign out_stall = out_tvalid && !out_tready;

  // a stalled result beat keeps valid and payload
  `SSP_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid, "result beat dropped")
  `SSP_ASSERT_NEXT(a_out_stable, out_stall, $stable({out_tlast, out_tdata}), "stalled beat changed")

  // one move at a time: the input closes right after a beat
  `SSP_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input open during a move")

  // every pulse width lies in the servo range
  `SSP_ASSERT_IMPL(a_pulse_range, out_tvalid, pulse_ok, "pulse width out of range")

endmodule

bind servo_step_profile_generator ssp_checker u_ssp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== verif/servo_step_profile_generator_test.sv =====
// self-checking testbench of the servo step profile generator: predicted ramps vs result beats
`timescale 1ns / 1ps

module servo_step_profile_generator_test;

  import ssp_pkg::*;

  // one expected result beat
  typedef struct {
    logic [PULSE_W-1:0]        pulse;
    logic [HOLD_W-1:0]         hold;
    logic signed [ANGLE_W-1:0] pos;
    logic                      last;
  } ramp_step_t;

  // predicts the ramp of each move and checks result beats in order
  class ramp_predictor;
    ramp_step_t steps_due[$];
    int         angle_now;
    bit         invert;
    int         errors;

    function new();
      angle_now = 0;
      invert    = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return steps_due.size();
    endfunction

    function logic [PULSE_W-1:0] pulse_width(int angle);
      int d;
      d = invert ? -angle : angle;
      if (d > ANGLE_LIMIT) d = ANGLE_LIMIT;
      if (d < -ANGLE_LIMIT) d = -ANGLE_LIMIT;
      d = d + ANGLE_LIMIT;
      return PULSE_W'(PULSE_BASE + (d * 50) / 9);
    endfunction

    function void push_step(int angle, logic [HOLD_W-1:0] hold, logic last);
      ramp_step_t s;
      s.pulse = pulse_width(angle);
      s.hold  = hold;
      s.pos   = ANGLE_W'(angle);
      s.last  = last;
      steps_due = {steps_due, s};
    endfunction

    // an accepted target: saturate, then walk toward it in fixed steps
    function void take_target(logic [ANGLE_W-1:0] target_raw, logic [HOLD_W-1:0] hold_raw);
      int               tgt;
      int               delta;
      int               dir;
      int               n_steps;
      int               n_inter;
      logic [HOLD_W-1:0] hold;
      tgt = $signed(target_raw);
      if (tgt > ANGLE_LIMIT) tgt = ANGLE_LIMIT;
      if (tgt < -ANGLE_LIMIT) tgt = -ANGLE_LIMIT;
      hold = (hold_raw < MIN_HOLD_MS) ? HOLD_W'(MIN_HOLD_MS) : hold_raw;
      delta = tgt - angle_now;
      dir = (delta >= 0) ? 1 : -1;
      n_steps = ((delta >= 0) ? delta : -delta) / STEP_DEG;
      if (n_steps == 0) return;
      n_inter = n_steps - 1;
      if (n_inter > MAX_RESULTS - 1) n_inter = MAX_RESULTS - 1;
      for (int k = 1; k <= n_inter; k++) push_step(angle_now + dir * STEP_DEG * k, hold, 1'b0);
      push_step(tgt, hold, 1'b1);
      angle_now = tgt;
    endfunction

    // compare one result beat with the oldest expected step
    function void check_step(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      ramp_step_t want;
      if (steps_due.size() == 0) begin
        errors++;
        $error("unexpected result beat: tdata %h tlast %b", tdata, tlast);
        return;
      end
      want = steps_due.pop_front();
      if (tdata[10:0] !== want.pulse) begin
        errors++;
        $error("pulse_us: expected %0d, got %0d", want.pulse, tdata[10:0]);
      end
      if (tdata[24:11] !== want.hold) begin
        errors++;
        $error("hold_ms: expected %0d, got %0d", want.hold, tdata[24:11]);
      end
      if (tdata[32:25] !== want.pos) begin
        errors++;
        $error("position_deg: expected %0d, got %0d", want.pos, $signed(tdata[32:25]));
      end
      if (tlast !== want.last) begin
        errors++;
        $error("last: expected %0d, got %0d", want.last, tlast);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data = 1'b0;

  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  ramp_predictor ramp = new();

  servo_step_profile_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // result side: random stalls, check every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ramp.check_step(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // offer one target beat, with random gaps ahead of it
  task automatic send_target(input logic [ANGLE_W-1:0] tgt, input logic [HOLD_W-1:0] hold);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, hold, tgt};
    do @(posedge clk); while (!in_tready);
    ramp.take_target(tgt, hold);
  endtask

  // stop sending and wait until every expected step has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (ramp.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_invert(input logic value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ramp.invert = value;
  endtask

  // mostly in-range targets, some saturating, some short moves
  function automatic logic [ANGLE_W-1:0] pick_target();
    int a;
    case ($urandom_range(9))
      0: a = $urandom_range(255);
      1, 2: begin
        a = ramp.angle_now + $urandom_range(18) - 9;
        if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
        if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
      end
      default: a = $urandom_range(180) - 90;
    endcase
    return ANGLE_W'(a);
  endfunction

  function automatic logic [HOLD_W-1:0] pick_hold();
    case ($urandom_range(3))
      0: return HOLD_W'($urandom_range(20));
      1: return HOLD_W'($urandom_range(16383));
      default: return HOLD_W'($urandom_range(10000));
    endcase
  endfunction

  // run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 6;
    recv_idle_pct = 58;
    write_invert(1'b0);

    // directed: short moves, single steps, saturation, longest ramps, hold limits
    send_target(8'sd5, 14'd0);
    send_target(-8'sd9, 14'd9);
    send_target(8'sd10, 14'd10);
    send_target(8'sd127, 14'd16383);
    send_target(-8'sd128, 14'd0);
    send_target(-8'sd90, 14'd5);
    send_target(8'sd90, 14'd10000);
    send_target(-8'sd91, 14'd1);
    send_target(8'sd91, 14'd11);
    send_target(8'sd85, 14'd11);
    send_target(8'sd0, 14'd1234);
    send_target(-8'sd19, 14'd9999);
    send_target(-8'sd10, 14'd7);
    send_target(-8'sd29, 14'd42);
    send_target(8'sd80, 14'd2);
    send_target(-8'sd1, 14'd8191);
    send_target(8'sd100, 14'd16383);
    send_target(-8'sd100, 14'd8192);

    // random phases, each under its own idling pattern and invert setting
    for (int ph = 0; ph < 3; ph++) begin
      write_invert(ph != 1);
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 6 : 0;
      for (int i = 0; i < 120; i++) begin
        if (i % 60 == 30) settle();
        send_target(pick_target(), pick_hold());
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (ramp.errors == 0 && ramp.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
